[hw/rtl/rotating_slack_bin_scheduler_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the rotating slack-bin scheduler
// Shared concurrent-assertion shorthands, clocked on clock, gated by reset.
// ---------------------------------------------------------------------------
`ifndef ROTATING_SLACK_BIN_SCHEDULER_ASSERT_SVH
`define ROTATING_SLACK_BIN_SCHEDULER_ASSERT_SVH

// cond holds at every edge out of reset
`define RSBS_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// cons holds in the same cycle as ante
`define RSBS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// cons holds in the cycle after ante
`define RSBS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/rsbs_pkg.sv]
// ---------------------------------------------------------------------------
// rsbs_pkg
// Word types, command/status bundles and fixed constants of the scheduler.
// ---------------------------------------------------------------------------
package rsbs_pkg;

   localparam int TIME_W    = 32;
   localparam int SLACK_W   = 32;
   localparam int SIZE_W    = 16;
   localparam int TAG_W     = 16;
   localparam int BINIX_W   = 7;
   localparam int QP_W      = 13;
   localparam int QB_W      = 29;

   localparam int BW_W       = 32;
   localparam int TPS_W      = 30;
   localparam int BR_W       = 37;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 37;

   // 8 * size * ticks_per_second fits in 49 bits
   localparam int PROD_W = 49;
   // divider: dividend covers slack + tx + bin_width - 1, divisor covers bit_rate
   localparam int DVD_W  = 51;
   localparam int DVS_W  = 37;
   localparam int VAL_W  = DVD_W + 1;

   localparam logic [BW_W-1:0]  BW_RESET  = 32'd1000000;
   localparam logic [TPS_W-1:0] TPS_RESET = 30'd1000000;
   localparam logic [BR_W-1:0]  BR_RESET  = 37'd1000000000;

   localparam logic [CSR_IDX_W-1:0] CSR_BIN_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_RATE  = 2'd2;

   localparam logic FN_ENQ = 1'b0;
   localparam logic FN_DEQ = 1'b1;

   localparam logic [1:0] ST_ENQ   = 2'd0;
   localparam logic [1:0] ST_DROP  = 2'd1;
   localparam logic [1:0] ST_DEQ   = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   localparam logic DIV_TX  = 1'b0;
   localparam logic DIV_BIN = 1'b1;

   typedef struct packed {
      logic                      func;
      logic [TIME_W-1:0]         time_now;
      logic signed [SLACK_W-1:0] slack;
      logic [SIZE_W-1:0]         pkt_size;
      logic [TAG_W-1:0]          pkt_tag;
   } req_word_type;

   typedef struct packed {
      logic [1:0]                status;
      logic [TAG_W-1:0]          out_tag;
      logic signed [SLACK_W-1:0] out_slack;
      logic [SIZE_W-1:0]         out_size;
      logic [BINIX_W-1:0]        bin_index;
      logic [QP_W-1:0]           queue_packets;
      logic [QB_W-1:0]           queue_bytes;
   } rsp_word_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic mul;
      logic rot_chk;
      logic div_start;
      logic div_sel;
      logic tx_cap;
      logic bin_one;
      logic bin_cap;
      logic meta_rd;
      logic enq_upd;
      logic scan_step;
      logic scan_sel;
      logic dq_pop;
      logic dq_fin;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic req_deq;
      logic tot_zero;
      logic div_done;
      logic val_pos;
      logic scan_hit;
   } stat_type;

endpackage

[hw/rtl/rsbs_div.sv]
// ---------------------------------------------------------------------------
// rsbs_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rsbs_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [rsbs_pkg::DVD_W-1:0] dvd,
   input  logic [rsbs_pkg::DVS_W-1:0] dvs,
   output logic [rsbs_pkg::DVD_W-1:0] quo,
   output logic                     done
);
   import rsbs_pkg::*;

   localparam int CW = $clog2(DVD_W);

   logic              busy_ff, done_ff;
   logic [CW-1:0]     cnt_ff;
   logic [DVS_W-1:0]  rem_ff, dvs_ff;
   logic [DVD_W-1:0]  quo_ff;
   logic [DVS_W:0]    trial, diff;
   logic              ge;
   logic [DVS_W-1:0]  rem_in;

   assign trial  = {rem_ff, quo_ff[DVD_W-1]};
   assign diff   = trial - {1'b0, dvs_ff};
   assign ge     = trial >= {1'b0, dvs_ff};
   assign rem_in = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(DVD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dvd;
         dvs_ff <= dvs;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[DVD_W-2:0], ge};
      end
   end

   assign quo  = quo_ff;
   assign done = done_ff;

endmodule

[hw/rtl/rsbs_dpath.sv]
// ---------------------------------------------------------------------------
// rsbs_dpath
// Bin metadata, packet store, transmit-time math, rotation and totals.
// ---------------------------------------------------------------------------
`include "rotating_slack_bin_scheduler_assert.svh"

module rsbs_dpath #(
   parameter int NUM_BINS  = 64,
   parameter int BIN_DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rsbs_pkg::req_word_type            req_data,
   input  logic                              csr_we,
   input  logic [rsbs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rsbs_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  rsbs_pkg::cmd_type                 cmd,
   output rsbs_pkg::stat_type                stat,
   output rsbs_pkg::rsp_word_type            rsp_data
);
   import rsbs_pkg::*;

   localparam int SLOTS  = NUM_BINS + 1;
   localparam int PHY_W  = $clog2(SLOTS);
   localparam int SUM_W  = PHY_W + 1;
   localparam int IDX_W  = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
   localparam int CNT_W  = $clog2(BIN_DEPTH + 1);
   localparam int META_W = 2 * IDX_W + CNT_W;
   localparam int DEPTH  = SLOTS * BIN_DEPTH;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int TOT_W  = $clog2(DEPTH + 1);
   localparam int ST_W   = SLACK_W + TIME_W + SIZE_W + TAG_W;

   localparam logic signed [SLACK_W+1:0] SLK_MAX = 34'sd2147483647;
   localparam logic signed [SLACK_W+1:0] SLK_MIN = -34'sd2147483648;

   // configuration
   logic [BW_W-1:0]  bw_ff;
   logic [TPS_W-1:0] tps_ff;
   logic [BR_W-1:0]  br_ff;

   // control state
   logic [PHY_W-1:0]  base_ff;
   logic [TIME_W-1:0] last_rot_ff;
   logic [SLOTS-1:0]  ne_ff;
   logic [SLOTS-1:0]  mvld_ff;
   logic              mvld_q_ff;
   logic [TOT_W-1:0]  tot_cnt_ff;
   logic [QB_W-1:0]   tot_byte_ff;

   // memories
   logic [META_W-1:0] meta_mem [SLOTS];
   logic [META_W-1:0] meta_q_ff;
   logic [ST_W-1:0]   st_mem [DEPTH];
   logic [ST_W-1:0]   st_q_ff;

   // payload
   req_word_type              req_ff;
   logic [PROD_W-1:0]         prod_ff;
   logic signed [VAL_W-1:0]   val_ff;
   logic [PHY_W-1:0]          bin_ff, p_ff, scan_l_ff, scan_p_ff;
   logic [1:0]                status_ff;
   logic [TAG_W-1:0]          o_tag_ff;
   logic signed [SLACK_W-1:0] o_slack_ff;
   logic [SIZE_W-1:0]         o_size_ff;

   logic [BW_W-1:0]   w_eff;
   logic [BR_W-1:0]   br_eff;
   logic [DVD_W-1:0]  div_dvd, bin_dvd, div_q;
   logic [DVS_W-1:0]  div_dvs;
   logic              div_done;
   logic [PHY_W-1:0]  bin_clamp, bin_in, p_in;
   logic [SUM_W-1:0]  psum;
   logic [IDX_W-1:0]  m_head, m_tail, idx_sel;
   logic [CNT_W-1:0]  m_cnt;
   logic              full, enq_go, meta_we, rot_go;
   logic [META_W-1:0] meta_wd;
   logic [ADDR_W-1:0] st_addr;
   logic [ST_W-1:0]   st_wd;
   logic [TIME_W-1:0] now;

   logic signed [SLACK_W-1:0] s_slack;
   logic [TIME_W-1:0]         s_arr;
   logic [SIZE_W-1:0]         s_size;
   logic [TAG_W-1:0]          s_tag;
   logic signed [TIME_W:0]    wait_d;
   logic signed [SLACK_W+1:0] ns;
   logic signed [SLACK_W-1:0] ns_sat;

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
      idx_inc = (i == IDX_W'(BIN_DEPTH - 1)) ? '0 : i + IDX_W'(1);
   endfunction

   assign now    = req_ff.time_now;
   assign w_eff  = (bw_ff == '0) ? BW_W'(1) : bw_ff;
   assign br_eff = (br_ff == '0) ? BR_W'(1) : br_ff;

   // divider operands: transmit time, then ceil(value / width)
   assign bin_dvd = val_ff[DVD_W-1:0] + DVD_W'(w_eff) - DVD_W'(1);
   assign div_dvd = (cmd.div_sel == DIV_BIN) ? bin_dvd : DVD_W'(prod_ff);
   assign div_dvs = (cmd.div_sel == DIV_BIN) ? DVS_W'(w_eff) : br_eff;

   rsbs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .dvd   (div_dvd),
      .dvs   (div_dvs),
      .quo   (div_q),
      .done  (div_done)
   );

   assign bin_clamp = (div_q > DVD_W'(NUM_BINS)) ? PHY_W'(NUM_BINS) : div_q[PHY_W-1:0];
   assign bin_in    = cmd.bin_cap ? bin_clamp : PHY_W'(1);
   assign psum      = {1'b0, base_ff} + {1'b0, bin_in};
   assign p_in      = (psum >= SUM_W'(SLOTS)) ? PHY_W'(psum - SUM_W'(SLOTS)) : psum[PHY_W-1:0];

   // metadata entry: {head, tail, count}; never-written entries read as zero
   assign m_head = mvld_q_ff ? meta_q_ff[META_W-1 -: IDX_W] : '0;
   assign m_tail = mvld_q_ff ? meta_q_ff[CNT_W +: IDX_W] : '0;
   assign m_cnt  = mvld_q_ff ? meta_q_ff[CNT_W-1:0] : '0;
   assign full   = m_cnt >= CNT_W'(BIN_DEPTH);
   assign enq_go = cmd.enq_upd && !full;
   assign meta_we = enq_go || cmd.dq_pop;
   assign meta_wd = cmd.dq_pop ? {idx_inc(m_head), m_tail, m_cnt - CNT_W'(1)}
                               : {m_head, idx_inc(m_tail), m_cnt + CNT_W'(1)};

   assign idx_sel = cmd.dq_pop ? m_head : m_tail;
   assign st_addr = ADDR_W'(p_ff) * ADDR_W'(BIN_DEPTH) + ADDR_W'(idx_sel);
   assign st_wd   = {req_ff.slack, now, req_ff.pkt_size, req_ff.pkt_tag};

   assign {s_slack, s_arr, s_size, s_tag} = st_q_ff;

   // waiting time and saturated slack update
   assign wait_d = $signed({1'b0, now}) - $signed({1'b0, s_arr});
   assign ns     = $signed({{2{s_slack[SLACK_W-1]}}, s_slack}) - $signed({wait_d[TIME_W], wait_d});
   assign ns_sat = (ns > SLK_MAX) ? SLK_MAX[SLACK_W-1:0] :
                   (ns < SLK_MIN) ? SLK_MIN[SLACK_W-1:0] : ns[SLACK_W-1:0];

   assign rot_go = cmd.rot_chk && !ne_ff[base_ff] && (now >= last_rot_ff) &&
                   ((now - last_rot_ff) > w_eff);

   always_ff @(posedge clock) begin
      if (meta_we)      meta_mem[p_ff] <= meta_wd;
      if (cmd.meta_rd)  meta_q_ff <= meta_mem[p_ff];
      if (enq_go)       st_mem[st_addr] <= st_wd;
      if (cmd.dq_pop)   st_q_ff <= st_mem[st_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff       <= BW_RESET;
         tps_ff      <= TPS_RESET;
         br_ff       <= BR_RESET;
         base_ff     <= '0;
         last_rot_ff <= '0;
         ne_ff       <= '0;
         mvld_ff     <= '0;
         mvld_q_ff   <= 1'b0;
         tot_cnt_ff  <= '0;
         tot_byte_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BIN_WIDTH: bw_ff  <= csr_wdata[BW_W-1:0];
               CSR_TICKS_PS:  tps_ff <= csr_wdata[TPS_W-1:0];
               CSR_BIT_RATE:  br_ff  <= csr_wdata[BR_W-1:0];
               default: ;
            endcase
         end
         if (rot_go) begin
            base_ff     <= (base_ff == PHY_W'(NUM_BINS)) ? '0 : base_ff + PHY_W'(1);
            last_rot_ff <= now;
         end
         if (cmd.meta_rd) mvld_q_ff <= mvld_ff[p_ff];
         if (meta_we)     mvld_ff[p_ff] <= 1'b1;
         if (enq_go) begin
            ne_ff[p_ff] <= 1'b1;
            tot_cnt_ff  <= tot_cnt_ff + TOT_W'(1);
            tot_byte_ff <= tot_byte_ff + QB_W'(req_ff.pkt_size);
         end
         if (cmd.dq_pop) ne_ff[p_ff] <= (m_cnt != CNT_W'(1));
         if (cmd.dq_fin) begin
            tot_cnt_ff  <= tot_cnt_ff - TOT_W'(1);
            tot_byte_ff <= tot_byte_ff - QB_W'(s_size);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff     <= req_data;
         status_ff  <= (req_data.func == FN_DEQ) ? ST_EMPTY : ST_ENQ;
         o_tag_ff   <= '0;
         o_slack_ff <= '0;
         o_size_ff  <= '0;
         bin_ff     <= '0;
         scan_l_ff  <= '0;
         scan_p_ff  <= base_ff;
      end
      if (cmd.mul) begin
         prod_ff <= {PROD_W'(req_ff.pkt_size) * PROD_W'(tps_ff)} << 3;
      end
      if (cmd.tx_cap) begin
         val_ff <= $signed(VAL_W'(req_ff.slack)) + $signed({1'b0, div_q});
      end
      if (cmd.bin_one || cmd.bin_cap) begin
         bin_ff <= bin_in;
         p_ff   <= p_in;
      end
      if (cmd.scan_step) begin
         scan_l_ff <= scan_l_ff + PHY_W'(1);
         scan_p_ff <= (scan_p_ff == PHY_W'(NUM_BINS)) ? '0 : scan_p_ff + PHY_W'(1);
      end
      if (cmd.scan_sel) begin
         bin_ff <= scan_l_ff;
         p_ff   <= scan_p_ff;
      end
      if (cmd.enq_upd) status_ff <= full ? ST_DROP : ST_ENQ;
      if (cmd.dq_fin) begin
         status_ff  <= ST_DEQ;
         o_tag_ff   <= s_tag;
         o_size_ff  <= s_size;
         o_slack_ff <= ns_sat;
      end
   end

   assign stat.req_deq  = (req_data.func == FN_DEQ);
   assign stat.tot_zero = (tot_cnt_ff == '0);
   assign stat.div_done = div_done;
   assign stat.val_pos  = (val_ff > 0);
   assign stat.scan_hit = ne_ff[scan_p_ff];

   assign rsp_data.status        = status_ff;
   assign rsp_data.out_tag       = o_tag_ff;
   assign rsp_data.out_slack     = o_slack_ff;
   assign rsp_data.out_size      = o_size_ff;
   assign rsp_data.bin_index     = BINIX_W'(bin_ff);
   assign rsp_data.queue_packets = QP_W'(tot_cnt_ff);
   assign rsp_data.queue_bytes   = tot_byte_ff;

   `RSBS_ASSERT_ALWAYS(a_tot_cap, tot_cnt_ff <= TOT_W'(DEPTH), "packet count beyond capacity")
   `RSBS_ASSERT_IMPL(a_pop_nonempty, cmd.dq_pop, m_cnt != '0, "pop from an empty bin")
   `RSBS_ASSERT_NEXT(a_enq_marks, enq_go, ne_ff[$past(p_ff)], "stored bin not marked busy")

endmodule

[hw/rtl/rsbs_ctrl.sv]
// ---------------------------------------------------------------------------
// rsbs_ctrl
// Operation sequencer: steps the datapath through enqueue or dequeue.
// ---------------------------------------------------------------------------
module rsbs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  rsbs_pkg::stat_type  stat,
   output rsbs_pkg::cmd_type   cmd
);
   import rsbs_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE = 13'b0000000000001,
      S_MUL  = 13'b0000000000010,
      S_TXS  = 13'b0000000000100,
      S_DTX  = 13'b0000000001000,
      S_VAL  = 13'b0000000010000,
      S_DBIN = 13'b0000000100000,
      S_ERD  = 13'b0000001000000,
      S_ENQ  = 13'b0000010000000,
      S_SCAN = 13'b0000100000000,
      S_DRD  = 13'b0001000000000,
      S_POP  = 13'b0010000000000,
      S_FIN  = 13'b0100000000000,
      S_RSP  = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (!stat.req_deq)     state_in = S_MUL;
               else if (stat.tot_zero) state_in = S_RSP;
               else                   state_in = S_SCAN;
            end
         end
         S_MUL: begin
            cmd.mul     = 1'b1;
            cmd.rot_chk = 1'b1;
            state_in    = S_TXS;
         end
         S_TXS: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_TX;
            state_in      = S_DTX;
         end
         S_DTX: begin
            if (stat.div_done) begin
               cmd.tx_cap = 1'b1;
               state_in   = S_VAL;
            end
         end
         S_VAL: begin
            if (stat.val_pos) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_BIN;
               state_in      = S_DBIN;
            end else begin
               cmd.bin_one = 1'b1;
               state_in    = S_ERD;
            end
         end
         S_DBIN: begin
            cmd.div_sel = DIV_BIN;
            if (stat.div_done) begin
               cmd.bin_cap = 1'b1;
               state_in    = S_ERD;
            end
         end
         S_ERD: begin
            cmd.meta_rd = 1'b1;
            state_in    = S_ENQ;
         end
         S_ENQ: begin
            cmd.enq_upd = 1'b1;
            state_in    = S_RSP;
         end
         S_SCAN: begin
            if (stat.scan_hit) begin
               cmd.scan_sel = 1'b1;
               state_in     = S_DRD;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_DRD: begin
            cmd.meta_rd = 1'b1;
            state_in    = S_POP;
         end
         S_POP: begin
            cmd.dq_pop = 1'b1;
            state_in   = S_FIN;
         end
         S_FIN: begin
            cmd.dq_fin  = 1'b1;
            cmd.rot_chk = 1'b1;
            state_in    = S_RSP;
         end
         S_RSP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RSP);

endmodule

[hw/rtl/rotating_slack_bin_scheduler.sv]
// ---------------------------------------------------------------------------
// rotating_slack_bin_scheduler
// Approximate least-slack-first packet scheduler over rotating FIFO bins.
// ---------------------------------------------------------------------------
// Each req word is an enqueue (func 0) or a dequeue (func 1) and yields
// exactly one rsp word. One operation is in flight at a time. Enqueue adds
// the transmit time floor(8*size*ticks_per_second/bit_rate) to the slack and
// files the packet in logical bin clamp(ceil(value/bin_width),1,NUM_BINS);
// both divisions run on one shared radix-2 divider, and the second one is
// skipped when slack plus transmit time is not positive. A dequeue scans up
// from the base bin for the lowest busy bin, checking one bin per cycle; an
// empty-queue dequeue skips the scan. Bins rotate by bumping a base pointer,
// never by copying. Bin metadata resets through per-bin valid bits, so
// there is no clearing pass and req_ready is high right out of reset. csr
// writes are always accepted and must only be issued while no operation
// is outstanding.
// ---------------------------------------------------------------------------
module rotating_slack_bin_scheduler #(
   parameter int NUM_BINS  = 64,
   parameter int BIN_DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   // request word
   input  logic                             req_valid,
   output logic                             req_ready,
   input  rsbs_pkg::req_word_type           req_data,
   // response word
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output rsbs_pkg::rsp_word_type           rsp_data,
   // register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rsbs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rsbs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rsbs_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // registers are plain flops, a write lands in the next cycle
   assign csr_ready = 1'b1;

   rsbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rsbs_dpath #(
      .NUM_BINS  (NUM_BINS),
      .BIN_DEPTH (BIN_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule
